// ----- sv/quadratic_exp_decay_eval_macros.svh -----
// Assertion macros used by the checker file of the decay evaluator.
`ifndef QUADRATIC_EXP_DECAY_EVAL_MACROS_SVH
`define QUADRATIC_EXP_DECAY_EVAL_MACROS_SVH

// Overlapping implication, checked on every rising clock edge outside reset.
`define QED_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: property check failed");

// Non-overlapping implication, checked on every rising clock edge outside reset.
`define QED_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: property check failed");

`endif

// ----- sv/qed_pkg.sv -----
// Package with constants, register codes and the exponent table rule of the decay evaluator.
package qed_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_COEF_CONST  = 3'd0,
        CFG_COEF_LINEAR = 3'd1,
        CFG_COEF_SQUARE = 3'd2,
        CFG_HEIGHT      = 3'd3,
        CFG_INV_LIFE    = 3'd4
    } t_cfg_reg;

    // Fixed-point constants.
    localparam logic [31:0] LOG2E_Q30  = 32'd1549082005;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [31:0] ONE_Q30    = 32'd1073741824;
    localparam logic [31:0] DIV6_RECIP = 32'd715827883;
    localparam logic signed [32:0] Z_LIMIT = 33'sd4278190080;

    // Register stages from input to output.
    localparam int PIPE_DEPTH = 12;

    // Q2.30 value of 2^(idx / 2^bits) by a series up to the twelfth power; used at elaboration.
    function automatic logic [31:0] exp_table_entry(input int unsigned idx,
                                                    input int unsigned bits);
        logic [63:0] g;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        g = (64'(idx) << (30 - bits)) & (64'(ONE_Q30) - 64'd1);
        t = (g * 64'(LN2_Q30)) >> 30;
        term = 64'(ONE_Q30);
        sum = 64'(ONE_Q30);
        for (int j = 1; j <= 12; j++) begin
            term = ((term * t) >> 30) / 64'(j);
            sum = sum + term;
        end
        return sum[31:0];
    endfunction

endpackage

// ----- sv/quadratic_exp_decay_eval.sv -----
// Pipelined evaluator of a quadratic times a decaying exponential in Q16.16.
//
//  Channel   Signals                                   Handshake
//  --------  ----------------------------------------  -----------------------
//  input     i_x, i_last_in                            start high, busy low
//  result    o_value, o_saturated, o_last_out          o_valid, one cycle
//  config    i_cfg_idx, i_cfg_data                     i_cfg_we, no wait
//
// Twelve register stages lie between an accepted item and its result.
// A new item is taken in every cycle, so busy stays low; the multipliers set the depth.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. The result side cannot stall, so nothing is ever held back.
module quadratic_exp_decay_eval #(
    parameter int EXP_TABLE_BITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_x,
    input  logic               i_last_in,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_value,
    output logic               o_saturated,
    output logic               o_last_out
);

    localparam int TBL_SIZE = 1 << EXP_TABLE_BITS;
    localparam int REST_W   = 24 - EXP_TABLE_BITS;
    localparam int DEPTH    = qed_pkg::PIPE_DEPTH;

    // Configuration registers.
    logic signed [31:0] r_coef_const;
    logic signed [31:0] r_coef_linear;
    logic signed [31:0] r_coef_square;
    logic signed [31:0] r_height;
    logic [30:0]        r_inv_life;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_const  <= '0;
            r_coef_linear <= '0;
            r_coef_square <= '0;
            r_height      <= 32'sd65536;
            r_inv_life    <= 31'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qed_pkg::CFG_COEF_CONST:  r_coef_const  <= i_cfg_data;
                qed_pkg::CFG_COEF_LINEAR: r_coef_linear <= i_cfg_data;
                qed_pkg::CFG_COEF_SQUARE: r_coef_square <= i_cfg_data;
                qed_pkg::CFG_HEIGHT:      r_height      <= i_cfg_data;
                qed_pkg::CFG_INV_LIFE:    r_inv_life    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Constant table of 2^(i/2^EXP_TABLE_BITS) in Q2.30.
    logic [31:0] w_exp_table [TBL_SIZE];
    for (genvar gi = 0; gi < TBL_SIZE; gi++) begin : g_tbl
        assign w_exp_table[gi] = qed_pkg::exp_table_entry(gi, EXP_TABLE_BITS);
    end

    // Valid and last-marker pipelines.
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_last;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start && !busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[DEPTH-2:0], i_last_in};
    end

    // Stage 1: the three input products.
    logic signed [63:0] r1_ax1, r1_ax2, r1_xi;
    logic signed [31:0] r1_x;
    always_ff @(posedge i_clk) begin
        r1_ax1 <= 64'(r_coef_linear) * 64'(i_x);
        r1_ax2 <= 64'(r_coef_square) * 64'(i_x);
        r1_xi  <= 64'(i_x) * $signed({33'd0, r_inv_life});
        r1_x   <= i_x;
    end

    // Stage 2: partial products of the square term; exponent argument clamp.
    logic signed [64:0] n2_plo;
    logic signed [63:0] n2_phi;
    logic signed [63:0] n2_zs;
    logic signed [32:0] n2_z;
    logic signed [64:0] r2_plo;
    logic signed [63:0] r2_phi, r2_ax1;
    logic signed [32:0] r2_z;
    always_comb begin
        n2_plo = 65'($signed({1'b0, r1_ax2[31:0]})) * 65'(r1_x);
        n2_phi = 64'($signed(r1_ax2[63:32])) * 64'(r1_x);
        n2_zs  = (-r1_xi) >>> 8;
        if (n2_zs > 64'(qed_pkg::Z_LIMIT)) begin
            n2_z = qed_pkg::Z_LIMIT;
        end else if (n2_zs < -64'(qed_pkg::Z_LIMIT)) begin
            n2_z = -qed_pkg::Z_LIMIT;
        end else begin
            n2_z = n2_zs[32:0];
        end
    end
    always_ff @(posedge i_clk) begin
        r2_plo <= n2_plo;
        r2_phi <= n2_phi;
        r2_ax1 <= r1_ax1;
        r2_z   <= n2_z;
    end

    // Stage 3: square term sum; base-2 exponent product.
    logic signed [95:0] r3_sq;
    logic signed [63:0] r3_ax1;
    logic signed [64:0] r3_yp;
    always_ff @(posedge i_clk) begin
        r3_sq  <= $signed({r2_phi, 32'd0}) + 96'(r2_plo);
        r3_ax1 <= r2_ax1;
        r3_yp  <= 65'(r2_z) * $signed({33'd0, qed_pkg::LOG2E_Q30});
    end

    // Stage 4: full quadratic; split the exponent and start the polynomial.
    logic [23:0]                 w4_f;
    logic [EXP_TABLE_BITS-1:0]   w4_idx;
    logic [REST_W-1:0]           w4_rest;
    logic [63:0]                 w4_tp;
    logic signed [95:0]          r4_q;
    logic signed [10:0]          r4_n;
    logic [29:0]                 r4_t;
    logic [31:0]                 r4_tab;
    always_comb begin
        w4_f    = r3_yp[53:30];
        w4_idx  = w4_f[23 -: EXP_TABLE_BITS];
        w4_rest = w4_f[REST_W-1:0];
        w4_tp   = 64'(w4_rest) * 64'(qed_pkg::LN2_Q30);
    end
    always_ff @(posedge i_clk) begin
        r4_q   <= 96'($signed({r_coef_const, 32'd0}))
                + $signed({{16{r3_ax1[63]}}, r3_ax1, 16'd0}) + r3_sq;
        r4_n   <= r3_yp[64:54];
        r4_t   <= w4_tp[53:24];
        r4_tab <= w_exp_table[w4_idx];
    end

    // Stage 5: magnitude of the quadratic; square of the remainder.
    logic [59:0] w5_tt;
    logic        r5_neg;
    logic [95:0] r5_mag;
    logic [29:0] r5_t, r5_t2;
    logic signed [10:0] r5_n;
    logic [31:0] r5_tab;
    assign w5_tt = 60'(r4_t) * 60'(r4_t);
    always_ff @(posedge i_clk) begin
        r5_neg <= r4_q[95];
        r5_mag <= r4_q[95] ? 96'(-r4_q) : 96'(r4_q);
        r5_t   <= r4_t;
        r5_t2  <= w5_tt[59:30];
        r5_n   <= r4_n;
        r5_tab <= r4_tab;
    end

    // Stage 6: quadratic times height in three slices; cube of the remainder.
    logic [31:0] w6_habs;
    logic [59:0] w6_ttt;
    logic [63:0] r6_pp0, r6_pp1, r6_pp2;
    logic        r6_neg;
    logic [29:0] r6_t, r6_t2, r6_t3;
    logic signed [10:0] r6_n;
    logic [31:0] r6_tab;
    assign w6_habs = r_height[31] ? 32'(-r_height) : 32'(r_height);
    assign w6_ttt  = 60'(r5_t2) * 60'(r5_t);
    always_ff @(posedge i_clk) begin
        r6_pp0 <= 64'(r5_mag[31:0]) * 64'(w6_habs);
        r6_pp1 <= 64'(r5_mag[63:32]) * 64'(w6_habs);
        r6_pp2 <= 64'(r5_mag[95:64]) * 64'(w6_habs);
        r6_neg <= r5_neg ^ r_height[31];
        r6_t   <= r5_t;
        r6_t2  <= r5_t2;
        r6_t3  <= w6_ttt[59:30];
        r6_n   <= r5_n;
        r6_tab <= r5_tab;
    end

    // Stage 7: product sum; cube divided by six through its reciprocal.
    logic [63:0]  w7_d6;
    logic [127:0] r7_p;
    logic         r7_neg;
    logic [29:0]  r7_t, r7_t2, r7_t3d;
    logic signed [10:0] r7_n;
    logic [31:0]  r7_tab;
    assign w7_d6 = 64'(r6_t3) * 64'(qed_pkg::DIV6_RECIP);
    always_ff @(posedge i_clk) begin
        r7_p   <= 128'(r6_pp0) + (128'(r6_pp1) << 32) + (128'(r6_pp2) << 64);
        r7_neg <= r6_neg;
        r7_t   <= r6_t;
        r7_t2  <= r6_t2;
        r7_t3d <= w7_d6[61:32];
        r7_n   <= r6_n;
        r7_tab <= r6_tab;
    end

    // Stage 8: bit length of the product; polynomial sum.
    logic [7:0]   w8_len;
    logic [127:0] r8_p;
    logic [7:0]   r8_len;
    logic         r8_neg;
    logic [31:0]  r8_pd;
    logic signed [10:0] r8_n;
    logic [31:0]  r8_tab;
    always_comb begin
        w8_len = '0;
        for (int i = 0; i < 128; i++) begin
            if (r7_p[i]) begin
                w8_len = 8'(i + 1);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        r8_p   <= r7_p;
        r8_len <= w8_len;
        r8_neg <= r7_neg;
        r8_pd  <= qed_pkg::ONE_Q30 + 32'(r7_t) + 32'(r7_t2 >> 1) + 32'(r7_t3d);
        r8_n   <= r7_n;
        r8_tab <= r7_tab;
    end

    // Stage 9: normalized mantissa; table entry times polynomial.
    logic [127:0] w9_sh;
    logic [31:0]  r9_mant;
    logic [63:0]  r9_mp;
    logic [7:0]   r9_len;
    logic         r9_zero, r9_neg;
    logic signed [10:0] r9_n;
    always_comb begin
        if (r8_len > 8'd32) begin
            w9_sh = r8_p >> (r8_len - 8'd32);
        end else begin
            w9_sh = r8_p << (8'd32 - r8_len);
        end
    end
    always_ff @(posedge i_clk) begin
        r9_mant <= w9_sh[31:0];
        r9_mp   <= 64'(r8_tab) * 64'(r8_pd);
        r9_len  <= r8_len;
        r9_zero <= (r8_len == 8'd0);
        r9_neg  <= r8_neg;
        r9_n    <= r8_n;
    end

    // Stage 10: rounded exponential mantissa and final shift count.
    logic [63:0]  w10_mr;
    logic [31:0]  r10_mexp, r10_mant;
    logic signed [11:0] r10_e;
    logic         r10_zero, r10_neg;
    assign w10_mr = r9_mp + 64'd536870912;
    always_ff @(posedge i_clk) begin
        r10_mexp <= w10_mr[61:30];
        r10_mant <= r9_mant;
        r10_e    <= $signed({4'd0, r9_len}) - 12'sd110 + 12'(r9_n);
        r10_zero <= r9_zero;
        r10_neg  <= r9_neg;
    end

    // Stage 11: mantissa product.
    logic [63:0]  r11_w;
    logic signed [11:0] r11_e;
    logic         r11_zero, r11_neg;
    always_ff @(posedge i_clk) begin
        r11_w    <= 64'(r10_mant) * 64'(r10_mexp);
        r11_e    <= r10_e;
        r11_zero <= r10_zero;
        r11_neg  <= r10_neg;
    end

    // Stage 12: scale, saturate and apply the sign.
    logic [11:0]  w12_sh;
    logic [63:0]  w12_m;
    logic [31:0]  n_out_value;
    logic         n_out_sat;
    logic [31:0]  r_out_value;
    logic         r_out_sat;
    always_comb begin
        w12_sh      = 12'(-r11_e);
        w12_m       = '0;
        n_out_value = '0;
        n_out_sat   = 1'b0;
        if (!r11_zero) begin
            if (r11_e >= 12'sd0) begin
                n_out_sat   = 1'b1;
                n_out_value = r11_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                if (w12_sh < 12'd64) begin
                    w12_m = r11_w >> w12_sh[5:0];
                end
                if (!r11_neg && w12_m > 64'h7FFF_FFFF) begin
                    n_out_sat   = 1'b1;
                    n_out_value = 32'h7FFF_FFFF;
                end else if (r11_neg && w12_m > 64'h8000_0000) begin
                    n_out_sat   = 1'b1;
                    n_out_value = 32'h8000_0000;
                end else begin
                    n_out_value = r11_neg ? 32'(-w12_m) : w12_m[31:0];
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_sat   <= n_out_sat;
    end

    assign o_valid     = r_vld[DEPTH-1];
    assign o_value     = r_out_value;
    assign o_saturated = r_out_sat;
    assign o_last_out  = r_last[DEPTH-1];

endmodule

// ----- sv/qed_checker.sv -----
// Port-level checker for the decay evaluator, with its bind statement.
`include "quadratic_exp_decay_eval_macros.svh"

module qed_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_last_in,
    input logic               o_valid,
    input logic signed [31:0] o_value,
    input logic               o_saturated,
    input logic               o_last_out
);

    // Every accepted item comes out after the pipeline depth, marker intact.
    `QED_ASSERT_IMP(a_latency, i_clk, i_rst_n, start && !busy, ##(qed_pkg::PIPE_DEPTH) (o_valid && o_last_out == $past(i_last_in, qed_pkg::PIPE_DEPTH)))

    // No result appears without an item accepted at the matching time.
    `QED_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_valid, $past(start && !busy, qed_pkg::PIPE_DEPTH))

    // A clipped result sits on one of the two range limits.
    `QED_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, o_valid && o_saturated, o_value == 32'sh7FFF_FFFF || o_value == 32'sh8000_0000)

    // The block never holds off the next item.
    `QED_ASSERT_NXT(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)

endmodule

bind quadratic_exp_decay_eval qed_checker u_qed_checker (.*);
